/* rtl/packet_port_steering_parser_macros.svh */
// Assertion macros shared by the packet port steering parser modules.
`ifndef PACKET_PORT_STEERING_PARSER_MACROS_SVH
`define PACKET_PORT_STEERING_PARSER_MACROS_SVH

// Check a plain property on every clock edge outside reset.
`define PSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that a condition implies a consequence in the next cycle.
`define PSP_ASSERT_NEXT(lbl, clk, rst_n, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/psp_pkg.sv */
// Types, constants and codes shared by the packet port steering parser.
package psp_pkg;

    // Upper bound on the queue count; the divisor is also capped at 256
    localparam int unsigned MAX_TRANSPORTS = 256;
    localparam int unsigned DIVISOR_CAP    = (MAX_TRANSPORTS < 256) ? MAX_TRANSPORTS : 256;
    localparam int unsigned DIV_W          = 9;

    // Frame field positions and protocol codes
    localparam logic [6:0]  POS_ETYPE_HI  = 7'd12;
    localparam logic [6:0]  POS_ETYPE_LO  = 7'd13;
    localparam logic [6:0]  POS_IP_START  = 7'd14;
    localparam logic [6:0]  POS_PROTOCOL  = 7'd23;
    localparam logic [6:0]  POS_MAX       = 7'd127;
    localparam logic [15:0] ETH_TYPE_IPV4 = 16'h0800;
    localparam logic [7:0]  PROTO_TCP     = 8'd6;
    localparam logic [7:0]  PROTO_UDP     = 8'd17;
    localparam logic [15:0] PORT_DHCP_SRV = 16'd67;
    localparam logic [15:0] PORT_DHCP_CLI = 16'd68;

    // Remainder unit: one dividend bit per cycle
    localparam int unsigned PORT_W    = 16;
    localparam int unsigned DIV_STEPS = PORT_W;
    localparam int unsigned STEP_W    = $clog2(DIV_STEPS);

    // Register index (word address bit 2)
    localparam logic REG_QUEUE_COUNT = 1'b0;

    typedef enum logic [1:0] {
        S_RECV,
        S_DIV,
        S_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic start_div;
        logic div_step;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic out_free;
    } t_stat;

endpackage

/* rtl/packet_port_steering_parser.sv */
// Top level of the packet port steering parser: configuration register and submodules.
//
// Steers Ethernet frames to transport queues by L4 source port.
// Input stream: one frame byte per transaction on s_tdata, s_tlast on the final
// byte. Output stream: one result per frame, m_tdata = queue id, m_tuser = truncated.
// Non-last bytes are taken one per cycle while the parser is receiving.
// After the last byte the source port is reduced modulo the queue count by a
// bit-serial remainder unit, one port bit per cycle, then the result is loaded into
// the output register, which raises m_tvalid.
// s_tready stays low from the last byte until the result is loaded. The output
// register parts the two sides: bytes of the next frame are taken while a result
// waits on a stalled receiver; the next finished remainder holds, with s_tready low,
// until that result is taken.
// The queue count register lies at byte address 0 (reset 1); zero acts as one and
// values above MAX_TRANSPORTS or 256 are clamped. Write it only with no frame in flight.
// Reset (synchronous, active low) clears the frame state, empties the output
// register and sets the queue count to 1.
module packet_port_steering_parser #(
    parameter int unsigned MAX_TRANSPORTS = psp_pkg::MAX_TRANSPORTS
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] frame_byte
    input  logic        s_tlast,   // last_byte
    // Output stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] transport_id
    output logic        m_tuser,   // [0] truncated
    // Configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    logic [psp_pkg::DIV_W-1:0] r_queue_count;
    logic                      cfg_write;
    psp_pkg::t_cmd             cmd;
    psp_pkg::t_stat            stat;

    // Write the queue count register
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_queue_count <= psp_pkg::DIV_W'(1);
        end else if (cfg_write && (paddr[2] == psp_pkg::REG_QUEUE_COUNT)) begin
            r_queue_count <= pwdata[psp_pkg::DIV_W-1:0];
        end
    end

    assign pready = 1'b1;
    assign prdata = (paddr[2] == psp_pkg::REG_QUEUE_COUNT)
                  ? {{(32 - psp_pkg::DIV_W){1'b0}}, r_queue_count} : 32'd0;

    psp_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tlast  (s_tlast),
        .o_s_tready (s_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    psp_dpath #(
        .MAX_TRANSPORTS (MAX_TRANSPORTS)
    ) u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_stat        (stat),
        .i_frame_byte  (s_tdata),
        .i_queue_count (r_queue_count),
        .o_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .o_m_tdata     (m_tdata),
        .o_m_tuser     (m_tuser)
    );

endmodule

/* rtl/psp_ctrl.sv */
// Controller state machine: byte intake, remainder sequencing and result hand-off.
`include "packet_port_steering_parser_macros.svh"

module psp_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_s_tvalid,
    input  logic           i_s_tlast,
    output logic           o_s_tready,
    output psp_pkg::t_cmd  o_cmd,
    input  psp_pkg::t_stat i_stat
);

    localparam logic [psp_pkg::STEP_W-1:0] STEP_LAST = psp_pkg::STEP_W'(psp_pkg::DIV_STEPS - 1);

    psp_pkg::t_state              r_state, n_state;
    logic [psp_pkg::STEP_W-1:0]   r_step, n_step;

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            psp_pkg::S_RECV: begin
                if (i_s_tvalid && i_s_tlast) n_state = psp_pkg::S_DIV;
            end
            psp_pkg::S_DIV: begin
                if (r_step == STEP_LAST) n_state = psp_pkg::S_DONE;
            end
            psp_pkg::S_DONE: begin
                if (i_stat.out_free) n_state = psp_pkg::S_RECV;
            end
            default: begin
                n_state = psp_pkg::S_RECV;
            end
        endcase
    end

    // Commands to the datapath
    always_comb begin
        o_s_tready       = (r_state == psp_pkg::S_RECV);
        o_cmd.capture    = o_s_tready && i_s_tvalid;
        o_cmd.start_div  = o_s_tready && i_s_tvalid && i_s_tlast;
        o_cmd.div_step   = (r_state == psp_pkg::S_DIV);
        o_cmd.load_out   = (r_state == psp_pkg::S_DONE) && i_stat.out_free;
    end

    // Count remainder steps
    always_comb begin
        n_step = o_cmd.div_step ? r_step + 1'b1 : '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= psp_pkg::S_RECV;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

    `PSP_ASSERT_NEXT(a_last_starts_div, i_clk, i_rst_n, o_cmd.start_div, (r_state == psp_pkg::S_DIV) && (r_step == '0), "last byte did not start the remainder")
    `PSP_ASSERT(a_step_only_div, i_clk, i_rst_n, (r_state != psp_pkg::S_DIV) -> (r_step == '0), "step counter running outside division")
    `PSP_ASSERT(a_one_cmd, i_clk, i_rst_n, $onehot0({o_cmd.capture, o_cmd.div_step, o_cmd.load_out}), "overlapping datapath commands")

endmodule

/* rtl/psp_dpath.sv */
// Datapath: frame field capture, classification, bit-serial remainder and output register.
`include "packet_port_steering_parser_macros.svh"

module psp_dpath #(
    parameter int unsigned MAX_TRANSPORTS = psp_pkg::MAX_TRANSPORTS
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  psp_pkg::t_cmd              i_cmd,
    output psp_pkg::t_stat             o_stat,
    input  logic [7:0]                 i_frame_byte,
    input  logic [psp_pkg::DIV_W-1:0]  i_queue_count,
    output logic                       o_m_tvalid,
    input  logic                       i_m_tready,
    output logic [7:0]                 o_m_tdata,
    output logic                       o_m_tuser
);

    // Divisor ceiling: the queue count limit, never above 256 so the id fits in 8 bits
    localparam int unsigned CAP_VALUE = (MAX_TRANSPORTS < 256) ? MAX_TRANSPORTS : 256;
    localparam logic [psp_pkg::DIV_W-1:0] CAP = psp_pkg::DIV_W'(CAP_VALUE);

    // Frame state
    logic [6:0]  r_pos, n_pos;
    logic [15:0] r_etype, n_etype;
    logic [7:0]  r_proto, n_proto;
    logic [3:0]  r_hdr_words, n_hdr_words;
    logic [15:0] r_port, n_port;
    logic [1:0]  r_seen, n_seen;

    // Remainder unit
    logic [psp_pkg::PORT_W-1:0] r_dvd;
    logic [psp_pkg::DIV_W-1:0]  r_rem;
    logic [psp_pkg::DIV_W-1:0]  r_div;
    logic                       r_trunc;

    // Output register
    logic        r_m_tvalid;
    logic [7:0]  r_m_tdata;
    logic        r_m_tuser;

    logic [6:0]               port_at;
    logic                     port_hit;
    logic                     l4;
    logic                     dhcp;
    logic                     port_ok;
    logic [psp_pkg::DIV_W-1:0] eff_div;
    logic [psp_pkg::DIV_W:0]  trial;
    logic [psp_pkg::DIV_W:0]  trial_diff;
    logic [psp_pkg::DIV_W-1:0] n_rem;

    // Update frame fields with the current byte
    always_comb begin
        n_etype     = r_etype;
        n_proto     = r_proto;
        n_hdr_words = r_hdr_words;
        if (r_pos == psp_pkg::POS_ETYPE_HI) n_etype[15:8] = i_frame_byte;
        if (r_pos == psp_pkg::POS_ETYPE_LO) n_etype[7:0]  = i_frame_byte;
        if (r_pos == psp_pkg::POS_IP_START) n_hdr_words   = i_frame_byte[3:0];
        if (r_pos == psp_pkg::POS_PROTOCOL) n_proto       = i_frame_byte;

        port_at  = psp_pkg::POS_IP_START + {1'b0, n_hdr_words, 2'b00};
        port_hit = (r_pos == port_at) || (r_pos == port_at + 7'd1);
        n_port   = port_hit ? {r_port[7:0], i_frame_byte} : r_port;
        n_seen   = (port_hit && (r_seen < 2'd2)) ? r_seen + 2'd1 : r_seen;
        n_pos    = (r_pos < psp_pkg::POS_MAX) ? r_pos + 7'd1 : r_pos;
    end

    // Classify the frame on its last byte
    always_comb begin
        l4 = (r_pos >= psp_pkg::POS_PROTOCOL) && (n_etype == psp_pkg::ETH_TYPE_IPV4) &&
             ((n_proto == psp_pkg::PROTO_TCP) || (n_proto == psp_pkg::PROTO_UDP));
        dhcp = (n_proto == psp_pkg::PROTO_UDP) &&
               ((n_port == psp_pkg::PORT_DHCP_SRV) || (n_port == psp_pkg::PORT_DHCP_CLI));
        port_ok = l4 && (n_seen == 2'd2) && !dhcp;
        if (i_queue_count == '0) begin
            eff_div = psp_pkg::DIV_W'(1);
        end else if (i_queue_count > CAP) begin
            eff_div = CAP;
        end else begin
            eff_div = i_queue_count;
        end
    end

    // One restoring remainder step
    always_comb begin
        trial      = {r_rem, r_dvd[psp_pkg::PORT_W-1]};
        trial_diff = trial - {1'b0, r_div};
        n_rem      = (trial >= {1'b0, r_div}) ? trial_diff[psp_pkg::DIV_W-1:0]
                                              : trial[psp_pkg::DIV_W-1:0];
    end

    // Capture fields; clear them after the last byte
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos       <= '0;
            r_etype     <= '0;
            r_proto     <= '0;
            r_hdr_words <= '0;
            r_port      <= '0;
            r_seen      <= '0;
        end else if (i_cmd.start_div) begin
            r_pos       <= '0;
            r_etype     <= '0;
            r_proto     <= '0;
            r_hdr_words <= '0;
            r_port      <= '0;
            r_seen      <= '0;
        end else if (i_cmd.capture) begin
            r_pos       <= n_pos;
            r_etype     <= n_etype;
            r_proto     <= n_proto;
            r_hdr_words <= n_hdr_words;
            r_port      <= n_port;
            r_seen      <= n_seen;
        end
    end

    // Load and advance the remainder unit
    always_ff @(posedge i_clk) begin
        if (i_cmd.start_div) begin
            r_dvd   <= port_ok ? n_port : '0;
            r_rem   <= '0;
            r_div   <= eff_div;
            r_trunc <= l4 && (n_seen != 2'd2);
        end else if (i_cmd.div_step) begin
            r_dvd   <= {r_dvd[psp_pkg::PORT_W-2:0], 1'b0};
            r_rem   <= n_rem;
        end
    end

    // Hold the result until the transaction completes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_tvalid <= 1'b0;
        end else if (i_cmd.load_out) begin
            r_m_tvalid <= 1'b1;
        end else if (i_m_tready) begin
            r_m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_m_tdata <= r_rem[7:0];
            r_m_tuser <= r_trunc;
        end
    end

    assign o_stat.out_free = !r_m_tvalid || i_m_tready;
    assign o_m_tvalid      = r_m_tvalid;
    assign o_m_tdata       = r_m_tdata;
    assign o_m_tuser       = r_m_tuser;

    `PSP_ASSERT(a_rem_below_div, i_clk, i_rst_n, i_cmd.load_out -> (r_rem < r_div), "remainder not below divisor at load")
    `PSP_ASSERT_NEXT(a_trunc_zero_id, i_clk, i_rst_n, i_cmd.load_out && r_trunc, o_m_tvalid && (o_m_tdata == 8'd0), "truncated frame with nonzero queue id")
    `PSP_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tuser), "result changed while stalled")

endmodule

/* tb/sv/tb.sv */
// Self-checking testbench for the packet port steering parser.
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [15:0] ETH_TYPE_ARP  = 16'h0806;
    localparam logic [7:0]  PROTO_ICMP    = 8'd1;
    localparam logic [2:0]  TC_ADDR       = {psp_pkg::REG_QUEUE_COUNT, 2'b00};
    localparam int          BYTE_TARGET   = 1050;
    localparam int          QUIESCE       = 20;   // result latency plus margin
    localparam int          WATCHDOG      = 4000;
    localparam int          DRAIN         = 40;

    typedef enum {
        F_IPV4,
        F_ARP,
        F_OTHER,
        F_NOISE
    } t_frame_kind;

    typedef struct {
        logic [7:0] id;
        logic       trunc;
    } t_steer;

    typedef struct {
        int          tc;      // queue count to write first, -1 keeps the current one
        t_frame_kind kind;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] port;
        int          len;     // 0 builds a frame that carries the whole port
        bit          pinned;  // expected result typed in below
        logic [7:0]  id;
        logic        trunc;
    } t_steer_row;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;   // [7:0] frame_byte
    logic        s_tlast;   // last_byte
    logic        m_tvalid;
    logic        m_tready;
    logic [7:0]  m_tdata;   // [7:0] transport_id
    logic        m_tuser;   // [0] truncated
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    packet_port_steering_parser dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tlast (s_tlast),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tuser (m_tuser),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Shadow of the parser state and the queue count register
    logic [6:0]  sh_pos;
    logic [15:0] sh_etype;
    logic [7:0]  sh_proto;
    logic [3:0]  sh_hwords;
    logic [15:0] sh_sport;
    logic [1:0]  sh_pseen;
    logic [8:0]  sh_count;

    t_steer      steer_due[$];
    t_steer_row  rows[$];
    logic [7:0]  frame_buf[$];

    bit          pin_valid;
    t_steer      pin_result;
    bit          tx_idle_on;
    bit          rx_idle_on;
    int          errors;
    int          bytes_sent;
    int          quiet_cycles;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Advance the shadow parser by one accepted byte; queue the result on the last one
    function automatic void steer_model_byte(logic [7:0] b, logic last);
        int     port_at;
        int     divisor;
        logic   known;
        logic   l4;
        t_steer res;
        port_at = int'(psp_pkg::POS_IP_START);
        if (sh_pos == psp_pkg::POS_ETYPE_HI) sh_etype[15:8] = b;
        if (sh_pos == psp_pkg::POS_ETYPE_LO) sh_etype[7:0] = b;
        if (sh_pos == psp_pkg::POS_IP_START) sh_hwords = b[3:0];
        if (sh_pos == psp_pkg::POS_PROTOCOL) sh_proto = b;
        port_at = port_at + 4 * int'(sh_hwords);
        if (int'(sh_pos) == port_at || int'(sh_pos) == port_at + 1) begin
            sh_sport = {sh_sport[7:0], b};
            if (sh_pseen < 2'd2) sh_pseen = sh_pseen + 2'd1;
        end
        known = (sh_pos >= psp_pkg::POS_PROTOCOL);
        if (sh_pos < psp_pkg::POS_MAX) sh_pos = sh_pos + 7'd1;
        if (!last) return;

        res.id    = 8'd0;
        res.trunc = 1'b0;
        l4 = known && sh_etype == psp_pkg::ETH_TYPE_IPV4 &&
             (sh_proto == psp_pkg::PROTO_TCP || sh_proto == psp_pkg::PROTO_UDP);
        if (l4) begin
            divisor = (sh_count == 9'd0) ? 1 : int'(sh_count);
            if (divisor > int'(psp_pkg::DIVISOR_CAP)) divisor = int'(psp_pkg::DIVISOR_CAP);
            if (sh_pseen < 2'd2)
                res.trunc = 1'b1;
            else if (sh_proto == psp_pkg::PROTO_UDP &&
                     (sh_sport == psp_pkg::PORT_DHCP_SRV ||
                      sh_sport == psp_pkg::PORT_DHCP_CLI))
                res.id = 8'd0;
            else
                res.id = 8'(int'(sh_sport) % divisor);
        end
        if (pin_valid) begin
            res       = pin_result;
            pin_valid = 1'b0;
        end
        steer_due.push_back(res);

        sh_pos    = '0;
        sh_etype  = '0;
        sh_proto  = '0;
        sh_hwords = '0;
        sh_sport  = '0;
        sh_pseen  = '0;
    endfunction

    // Check results, track accepted bytes and register writes, feed the watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (psel && penable))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (m_tvalid && m_tready) begin
                if (steer_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, actual id %0d trunc %0b",
                             $time, m_tdata, m_tuser);
                    errors++;
                end else begin
                    if (m_tdata !== steer_due[0].id) begin
                        $display("%0t: transport id mismatch, expected %0d, actual %0d",
                                 $time, steer_due[0].id, m_tdata);
                        errors++;
                    end
                    if (m_tuser !== steer_due[0].trunc) begin
                        $display("%0t: truncated flag mismatch, expected %0b, actual %0b",
                                 $time, steer_due[0].trunc, m_tuser);
                        errors++;
                    end
                    void'(steer_due.pop_front());
                end
            end
            if (s_tvalid && s_tready) steer_model_byte(s_tdata, s_tlast);
            if (psel && penable && pwrite && pready && paddr == TC_ADDR)
                sh_count = pwdata[8:0];
        end
    end

    // Stall the result side at random
    always @(negedge i_clk) begin
        m_tready <= rx_idle_on ? ($urandom_range(99) >= 38) : 1'b1;
    end

    // Watchdog on cycles without any transaction
    initial begin
        while (quiet_cycles < WATCHDOG) @(posedge i_clk);
        $display("tb failed");
        $finish;
    end

    function automatic void build_frame(t_frame_kind kind, logic [3:0] ihl, logic [7:0] proto,
                                        logic [15:0] port, int len);
        int          port_at;
        int          n;
        logic [15:0] etype;
        port_at = 14 + 4 * int'(ihl);
        n = (len > 0) ? len : port_at + 2 + $urandom_range(0, 6);
        frame_buf.delete();
        for (int i = 0; i < n; i++) frame_buf.push_back(8'($urandom));
        if (kind == F_NOISE) return;
        case (kind)
            F_IPV4:  etype = psp_pkg::ETH_TYPE_IPV4;
            F_ARP:   etype = ETH_TYPE_ARP;
            default: begin
                etype = 16'($urandom);
                if (etype == psp_pkg::ETH_TYPE_IPV4) etype[0] = 1'b1;
            end
        endcase
        // Port first, then header fields: overlapping bytes keep their header value
        if (port_at < n)     frame_buf[port_at]     = port[15:8];
        if (port_at + 1 < n) frame_buf[port_at + 1] = port[7:0];
        if (12 < n) frame_buf[12] = etype[15:8];
        if (13 < n) frame_buf[13] = etype[7:0];
        if (14 < n) frame_buf[14] = {frame_buf[14][7:4], ihl};
        if (23 < n) frame_buf[23] = proto;
    endfunction

    // Drive one byte and hold it until it is taken
    task automatic send_byte(logic [7:0] b, logic last);
        while (tx_idle_on && $urandom_range(99) < 38) begin
            s_tvalid <= 1'b0;
            @(negedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= last;
        do @(posedge i_clk); while (!(s_tvalid && s_tready));
        @(negedge i_clk);
        bytes_sent++;
    endtask

    task automatic send_frame();
        for (int i = 0; i < frame_buf.size(); i++)
            send_byte(frame_buf[i], i == frame_buf.size() - 1);
    endtask

    // Drain all results, let the block settle, then write and read back the queue count
    task automatic set_queue_count(int value);
        logic [31:0] wdata;
        s_tvalid <= 1'b0;
        while (steer_due.size() != 0) @(negedge i_clk);
        repeat (QUIESCE) @(negedge i_clk);
        wdata = {23'($urandom), 9'(value)};
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TC_ADDR;
        pwdata  <= wdata;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[8:0] !== wdata[8:0]) begin
            $display("%0t: queue count readback mismatch, expected %0d, actual %0d",
                     $time, wdata[8:0], prdata[8:0]);
            errors++;
        end
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic add_row(int tc, t_frame_kind kind, logic [3:0] ihl, logic [7:0] proto,
                           logic [15:0] port, int len, bit pinned, logic [7:0] id,
                           logic trunc);
        t_steer_row r;
        r.tc     = tc;
        r.kind   = kind;
        r.ihl    = ihl;
        r.proto  = proto;
        r.port   = port;
        r.len    = len;
        r.pinned = pinned;
        r.id     = id;
        r.trunc  = trunc;
        rows.push_back(r);
    endtask

    // Pick one random frame, mostly well-formed TCP/UDP with random content
    task automatic random_frame();
        int          r;
        logic [3:0]  ihl;
        logic [7:0]  proto;
        logic [15:0] port;
        int          sel;
        r     = $urandom_range(99);
        ihl   = ($urandom_range(1) == 0) ? 4'd5 : 4'($urandom);
        proto = ($urandom_range(1) == 0) ? psp_pkg::PROTO_TCP : psp_pkg::PROTO_UDP;
        sel   = $urandom_range(99);
        if (sel < 15)
            port = ($urandom_range(1) == 0) ? psp_pkg::PORT_DHCP_SRV : psp_pkg::PORT_DHCP_CLI;
        else if (sel < 25)
            port = ($urandom_range(1) == 0) ? 16'h0000 : 16'hFFFF;
        else
            port = 16'($urandom);
        if (r < 62) begin
            build_frame(F_IPV4, ihl, proto, port, 0);
        end else if (r < 72) begin
            // End inside or before the port of a TCP/UDP frame
            ihl = 4'($urandom_range(3, 15));
            build_frame(F_IPV4, ihl, proto, port, $urandom_range(24, 15 + 4 * int'(ihl)));
        end else if (r < 80) begin
            build_frame(($urandom_range(1) == 0) ? F_ARP : F_OTHER, ihl, proto, port, 0);
        end else if (r < 87) begin
            build_frame(F_IPV4, ihl, 8'($urandom), port, 0);
        end else if (r < 95) begin
            build_frame(F_NOISE, ihl, proto, port, $urandom_range(1, 40));
        end else if (r < 98) begin
            build_frame(F_IPV4, ihl, proto, port, $urandom_range(1, 23));
        end else begin
            build_frame(F_IPV4, ihl, proto, port, $urandom_range(128, 150));
        end
        send_frame();
    endtask

    initial begin
        int tc_list[$];
        int phase;
        int nframes;
        i_rst_n    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        s_tlast    = 1'b0;
        m_tready   = 1'b0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        pin_valid  = 1'b0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        errors     = 0;
        bytes_sent = 0;
        quiet_cycles = 0;
        sh_pos    = '0;
        sh_etype  = '0;
        sh_proto  = '0;
        sh_hwords = '0;
        sh_sport  = '0;
        sh_pseen  = '0;
        sh_count  = 9'd1;

        // Directed frames: count, kind, ihl, proto, port, length, typed result
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'h1234, 0,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'h1234, 1,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'h1234, 20,  1, 8'd0,   1'b0);
        add_row(256, F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'hFFFF, 0,   1, 8'd255, 1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'd67,   0,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'd68,   0,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'd67,   0,   1, 8'd67,  1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'h00FF, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'h5678, 35,  1, 8'd0,   1'b1);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'h5678, 24,  1, 8'd0,   1'b1);
        add_row(-1,  F_ARP,   4'd5,  psp_pkg::PROTO_TCP, 16'h4321, 0,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  PROTO_ICMP,         16'h4321, 0,   1, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd0,  psp_pkg::PROTO_TCP, 16'hA0B7, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd1,  psp_pkg::PROTO_UDP, 16'h9C3E, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd2,  psp_pkg::PROTO_TCP, 16'h7F11, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd15, psp_pkg::PROTO_UDP, 16'hC3A5, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'h0F0F, 140, 0, 8'd0,   1'b0);
        add_row(0,   F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'hABCD, 0,   1, 8'd0,   1'b0);
        add_row(511, F_IPV4,  4'd5,  psp_pkg::PROTO_TCP, 16'hFFFF, 0,   1, 8'd255, 1'b0);
        add_row(257, F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'h0101, 0,   1, 8'd1,   1'b0);
        add_row(7,   F_IPV4,  4'd5,  psp_pkg::PROTO_UDP, 16'h2D9B, 0,   0, 8'd0,   1'b0);
        add_row(2,   F_OTHER, 4'd5,  psp_pkg::PROTO_UDP, 16'h0045, 0,   0, 8'd0,   1'b0);
        add_row(-1,  F_NOISE, 4'd5,  psp_pkg::PROTO_TCP, 16'h0000, 30,  0, 8'd0,   1'b0);

        // Hold reset, then release it at a falling edge
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (rows[i]) begin
            if (rows[i].tc >= 0) set_queue_count(rows[i].tc);
            build_frame(rows[i].kind, rows[i].ihl, rows[i].proto, rows[i].port, rows[i].len);
            pin_valid        = rows[i].pinned;
            pin_result.id    = rows[i].id;
            pin_result.trunc = rows[i].trunc;
            send_frame();
        end

        // Random phases, each under its own queue count; the first runs without stalls
        tc_list = '{3, 16, 256, 100, 255, 511, 1, 257, 0, 2, 128};
        phase = 0;
        while (bytes_sent < BYTE_TARGET) begin
            set_queue_count((phase < tc_list.size()) ? tc_list[phase] : $urandom_range(511));
            tx_idle_on = (phase != 0);
            rx_idle_on = (phase != 0);
            nframes = $urandom_range(2, 4);
            for (int k = 0; k < nframes && (phase == 0 || bytes_sent < BYTE_TARGET); k++)
                random_frame();
            phase++;
        end
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        s_tvalid  <= 1'b0;

        // Drain outstanding results, then watch for strays
        while (steer_due.size() != 0) @(posedge i_clk);
        repeat (DRAIN) @(posedge i_clk);
        if (errors == 0 && steer_due.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

endmodule
